@@ design/sba_pkg.sv @@
// Shared types, register codes and the reciprocal table for the
// space-to-batch address map. No dependencies.
`default_nettype none

package sba_pkg;

    localparam int unsigned MAX_BATCH    = 16;
    localparam int unsigned MAX_CHANNELS = 1024;
    localparam int unsigned MAX_HEIGHT   = 1024;
    localparam int unsigned MAX_WIDTH    = 1024;
    localparam int unsigned MAX_BLOCK    = 8;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned RECIP_W = 17;
    localparam int unsigned RECIP_SHIFT = 16;

    localparam logic [2:0] REG_IN_BATCH      = 3'd0;
    localparam logic [2:0] REG_CHANNELS      = 3'd1;
    localparam logic [2:0] REG_IN_HEIGHT     = 3'd2;
    localparam logic [2:0] REG_IN_WIDTH      = 3'd3;
    localparam logic [2:0] REG_BLOCK_WIDTH   = 3'd4;
    localparam logic [2:0] REG_BLOCK_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_PAD_TOP_ROWS  = 3'd6;
    localparam logic [2:0] REG_PAD_LEFT_COLS = 3'd7;

    // Saturated configuration as used by the datapath.
    typedef struct packed {
        logic [4:0]         nb;
        logic [10:0]        nc;
        logic [10:0]        nh;
        logic [10:0]        nw;
        logic [3:0]         bw;
        logic [3:0]         bh;
        logic [5:0]         top_pad;
        logic [5:0]         left_pad;
        logic [RECIP_W-1:0] recip_b;
        logic [RECIP_W-1:0] recip_w;
    } cfg_t;

    // Front half result: source batch, block shifts and the passed-through coordinates.
    typedef struct packed {
        logic       valid;
        logic [3:0] src_b;
        logic [2:0] sw;
        logic [9:0] sh;
        logic [9:0] ch;
        logic [9:0] orow;
        logic [9:0] ocol;
    } front_t;

    // floor(2^16 / d) for d in 1..16.
    function automatic logic [RECIP_W-1:0] recip(input logic [4:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21845;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13107;
            5'd6:    r = 17'd10922;
            5'd7:    r = 17'd9362;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7281;
            5'd10:   r = 17'd6553;
            5'd11:   r = 17'd5957;
            5'd12:   r = 17'd5461;
            5'd13:   r = 17'd5041;
            5'd14:   r = 17'd4681;
            5'd15:   r = 17'd4369;
            5'd16:   r = 17'd4096;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/sba_in_if.sv @@
// Input channel: coordinates of one output element.
// Depends on nothing.
`default_nettype none

interface sba_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_batch;
    logic [9:0] channel;
    logic [9:0] out_row;
    logic [9:0] out_col;

    modport source (output valid, output out_batch, output channel, output out_row,
                    output out_col, input ready);
    modport sink   (input valid, input out_batch, input channel, input out_row,
                    input out_col, output ready);
endinterface

`default_nettype wire

@@ design/sba_out_if.sv @@
// Output channel: flat source index and padding flag.
// Depends on nothing.
`default_nettype none

interface sba_out_if;
    logic        valid;
    logic        ready;
    logic [33:0] source_index;
    logic        is_padding;

    modport source (output valid, output source_index, output is_padding, input ready);
    modport sink   (input valid, input source_index, input is_padding, output ready);
endinterface

`default_nettype wire

@@ design/sba_cfg.sv @@
// APB register file with saturation of the shape registers.
// Depends on sba_pkg.
`default_nettype none

module sba_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sba_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sba_pkg::DATA_W-1:0] pwdata,
    output logic      [sba_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sba_pkg::cfg_t                   cfg
);
    import sba_pkg::*;

    logic [4:0]  in_batch_reg;
    logic [10:0] channels_reg;
    logic [10:0] in_height_reg;
    logic [10:0] in_width_reg;
    logic [3:0]  block_width_reg;
    logic [3:0]  block_height_reg;
    logic [5:0]  top_pad_rows_reg;
    logic [5:0]  left_pad_cols_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_batch_reg      <= 5'd1;
            channels_reg      <= 11'd1;
            in_height_reg     <= 11'd1;
            in_width_reg      <= 11'd1;
            block_width_reg   <= 4'd1;
            block_height_reg  <= 4'd1;
            top_pad_rows_reg  <= 6'd0;
            left_pad_cols_reg <= 6'd0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_IN_BATCH:      in_batch_reg      <= pwdata[4:0];
                REG_CHANNELS:      channels_reg      <= pwdata[10:0];
                REG_IN_HEIGHT:     in_height_reg     <= pwdata[10:0];
                REG_IN_WIDTH:      in_width_reg      <= pwdata[10:0];
                REG_BLOCK_WIDTH:   block_width_reg   <= pwdata[3:0];
                REG_BLOCK_HEIGHT:  block_height_reg  <= pwdata[3:0];
                REG_PAD_TOP_ROWS:  top_pad_rows_reg  <= pwdata[5:0];
                REG_PAD_LEFT_COLS: left_pad_cols_reg <= pwdata[5:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IN_BATCH:      prdata = {27'd0, in_batch_reg};
            REG_CHANNELS:      prdata = {21'd0, channels_reg};
            REG_IN_HEIGHT:     prdata = {21'd0, in_height_reg};
            REG_IN_WIDTH:      prdata = {21'd0, in_width_reg};
            REG_BLOCK_WIDTH:   prdata = {28'd0, block_width_reg};
            REG_BLOCK_HEIGHT:  prdata = {28'd0, block_height_reg};
            REG_PAD_TOP_ROWS:  prdata = {26'd0, top_pad_rows_reg};
            REG_PAD_LEFT_COLS: prdata = {26'd0, left_pad_cols_reg};
            default:           prdata = '0;
        endcase
    end

    // zero acts as one, oversize clips to the maximum
    always_comb
    begin
        cfg.nb = (in_batch_reg == 5'd0) ? 5'd1 :
                 (in_batch_reg > 5'(MAX_BATCH)) ? 5'(MAX_BATCH) : in_batch_reg;
        cfg.nc = (channels_reg == 11'd0) ? 11'd1 :
                 (channels_reg > 11'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : channels_reg;
        cfg.nh = (in_height_reg == 11'd0) ? 11'd1 :
                 (in_height_reg > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : in_height_reg;
        cfg.nw = (in_width_reg == 11'd0) ? 11'd1 :
                 (in_width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : in_width_reg;
        cfg.bw = (block_width_reg == 4'd0) ? 4'd1 :
                 (block_width_reg > 4'(MAX_BLOCK)) ? 4'(MAX_BLOCK) : block_width_reg;
        cfg.bh = (block_height_reg == 4'd0) ? 4'd1 :
                 (block_height_reg > 4'(MAX_BLOCK)) ? 4'(MAX_BLOCK) : block_height_reg;
        cfg.top_pad  = top_pad_rows_reg;
        cfg.left_pad = left_pad_cols_reg;
        cfg.recip_b  = recip(cfg.nb);
        cfg.recip_w  = recip({1'b0, cfg.bw});
    end

endmodule

`default_nettype wire

@@ design/sba_front.sv @@
// Stages 1-4: out_batch / in_batch, then quotient / block_width, each by
// reciprocal multiply followed by a one-step correction. Depends on sba_pkg.
`default_nettype none

module sba_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [9:0]    out_batch,
    input  wire logic [9:0]    channel,
    input  wire logic [9:0]    out_row,
    input  wire logic [9:0]    out_col,
    input  wire sba_pkg::cfg_t cfg,
    output sba_pkg::front_t    front
);
    import sba_pkg::*;

    // stage 1
    logic       v1_reg;
    logic [9:0] ob1_reg, ch1_reg, orow1_reg, ocol1_reg, qe1_reg;
    logic [26:0] prod1_next;
    // stage 2
    logic       v2_reg;
    logic [9:0] ch2_reg, orow2_reg, ocol2_reg, quo2_reg;
    logic [3:0] srcb2_reg;
    logic [9:0] rem2_next, quo2_next;
    logic [3:0] srcb2_next;
    // stage 3
    logic       v3_reg;
    logic [9:0] ch3_reg, orow3_reg, ocol3_reg, quo3_reg, qe3_reg;
    logic [3:0] srcb3_reg;
    logic [26:0] prod3_next;
    // stage 4
    logic       v4_reg;
    logic [9:0] ch4_reg, orow4_reg, ocol4_reg, sh4_reg;
    logic [3:0] srcb4_reg;
    logic [2:0] sw4_reg;
    logic [9:0] rem4_next, sh4_next;
    logic [2:0] sw4_next;

    // estimate is exact or one short
    assign prod1_next = 27'(out_batch) * 27'(cfg.recip_b);
    assign prod3_next = 27'(quo2_reg) * 27'(cfg.recip_w);

    always_comb
    begin
        rem2_next = ob1_reg - 10'(qe1_reg * 10'(cfg.nb));
        if (rem2_next >= 10'(cfg.nb))
        begin
            quo2_next  = qe1_reg + 10'd1;
            srcb2_next = 4'(rem2_next - 10'(cfg.nb));
        end
        else
        begin
            quo2_next  = qe1_reg;
            srcb2_next = rem2_next[3:0];
        end
    end

    always_comb
    begin
        rem4_next = quo3_reg - 10'(qe3_reg * 10'(cfg.bw));
        if (rem4_next >= 10'(cfg.bw))
        begin
            sh4_next = qe3_reg + 10'd1;
            sw4_next = 3'(rem4_next - 10'(cfg.bw));
        end
        else
        begin
            sh4_next = qe3_reg;
            sw4_next = rem4_next[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ob1_reg   <= out_batch;
            ch1_reg   <= channel;
            orow1_reg <= out_row;
            ocol1_reg <= out_col;
            qe1_reg   <= prod1_next[RECIP_SHIFT+9:RECIP_SHIFT];

            ch2_reg   <= ch1_reg;
            orow2_reg <= orow1_reg;
            ocol2_reg <= ocol1_reg;
            quo2_reg  <= quo2_next;
            srcb2_reg <= srcb2_next;

            ch3_reg   <= ch2_reg;
            orow3_reg <= orow2_reg;
            ocol3_reg <= ocol2_reg;
            quo3_reg  <= quo2_reg;
            srcb3_reg <= srcb2_reg;
            qe3_reg   <= prod3_next[RECIP_SHIFT+9:RECIP_SHIFT];

            ch4_reg   <= ch3_reg;
            orow4_reg <= orow3_reg;
            ocol4_reg <= ocol3_reg;
            srcb4_reg <= srcb3_reg;
            sh4_reg   <= sh4_next;
            sw4_reg   <= sw4_next;
        end
    end

    assign front.valid = v4_reg;
    assign front.src_b = srcb4_reg;
    assign front.sw    = sw4_reg;
    assign front.sh    = sh4_reg;
    assign front.ch    = ch4_reg;
    assign front.orow  = orow4_reg;
    assign front.ocol  = ocol4_reg;

endmodule

`default_nettype wire

@@ design/sba_back.sv @@
// Stages 5-8: padded position, bounds test and the flat NCHW index.
// Depends on sba_pkg.
`default_nettype none

module sba_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire sba_pkg::front_t front,
    input  wire sba_pkg::cfg_t   cfg,
    output logic                 out_valid,
    output logic [33:0]          source_index,
    output logic                 is_padding
);
    import sba_pkg::*;

    // stage 5
    logic        v5_reg;
    logic [13:0] prow5_reg, pcol5_reg, t05_reg;
    // stage 6
    logic        v6_reg, pad6_reg;
    logic [23:0] t16_reg;
    logic [13:0] r6_reg, c6_reg;
    logic        pad6_next;
    logic [11:0] row_end, col_end;
    // stage 7
    logic        v7_reg, pad7_reg;
    logic [35:0] prod7_reg;
    logic [13:0] c7_reg;
    // stage 8
    logic        v8_reg, pad8_reg;
    logic [33:0] idx8_reg;
    logic [35:0] sum8_next;

    assign row_end = 12'(cfg.top_pad) + 12'(cfg.nh);
    assign col_end = 12'(cfg.left_pad) + 12'(cfg.nw);

    assign pad6_next = (prow5_reg < 14'(cfg.top_pad)) || (prow5_reg >= 14'(row_end)) ||
                       (pcol5_reg < 14'(cfg.left_pad)) || (pcol5_reg >= 14'(col_end));

    assign sum8_next = prod7_reg + 36'(c7_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= front.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prow5_reg <= 14'(front.orow) * 14'(cfg.bh) + 14'(front.sh);
            pcol5_reg <= 14'(front.ocol) * 14'(cfg.bw) + 14'(front.sw);
            t05_reg   <= 14'(front.src_b) * 14'(cfg.nc) + 14'(front.ch);

            t16_reg   <= 24'(t05_reg) * 24'(cfg.nh);
            r6_reg    <= prow5_reg - 14'(cfg.top_pad);
            c6_reg    <= pcol5_reg - 14'(cfg.left_pad);
            pad6_reg  <= pad6_next;

            prod7_reg <= 36'(25'(t16_reg) + 25'(r6_reg)) * 36'(cfg.nw);
            c7_reg    <= c6_reg;
            pad7_reg  <= pad6_reg;

            idx8_reg  <= pad7_reg ? 34'd0 : sum8_next[33:0];
            pad8_reg  <= pad7_reg;
        end
    end

    assign out_valid    = v8_reg;
    assign source_index = idx8_reg;
    assign is_padding   = pad8_reg;

endmodule

`default_nettype wire

@@ design/space_to_batch_address_map.sv @@
// Top level of the space-to-batch address map: APB register file, divide
// front half and index back half. Depends on sba_pkg, sba_in_if, sba_out_if.
//
// Usage:
//   din carries one output element (out_batch, channel, out_row, out_col);
//   dout returns its flat NCHW source index and a padding flag, one result
//   per item, in order. Both use valid/ready; an item moves when both are high.
//   The APB port holds eight shape registers at byte address 4*i, always ready.
//   Write them only while no item is in flight.
// Pipeline: 8 register stages between the edge that accepts an item and dout;
//   dout.valid is the valid bit of the last stage.
// Throughput: one item per cycle when not stalled; eight register stages,
//   two reciprocal-multiply dividers, then position, bounds and index math.
// Stall: when dout holds a result and dout.ready is low, the whole pipeline
//   freezes and din.ready drops; nothing is lost or repeated.
// Reset: rst_n clears all stage valid bits and sets the registers to their
//   defaults (sizes one, padding zero).
`default_nettype none

module space_to_batch_address_map (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sba_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sba_pkg::DATA_W-1:0] pwdata,
    output logic      [sba_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    sba_in_if.sink                          din,
    sba_out_if.source                       dout
);
    import sba_pkg::*;

    cfg_t   cfg;
    front_t front;
    logic   en;

    // advance unless the last stage holds a result nobody takes
    assign en        = !dout.valid || dout.ready;
    assign din.ready = en;

    sba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (din.valid),
        .out_batch (din.out_batch),
        .channel   (din.channel),
        .out_row   (din.out_row),
        .out_col   (din.out_col),
        .cfg       (cfg),
        .front     (front)
    );

    sba_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .front        (front),
        .cfg          (cfg),
        .out_valid    (dout.valid),
        .source_index (dout.source_index),
        .is_padding   (dout.is_padding)
    );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for space_to_batch_address_map: drives coordinates and APB shape writes,
// predicts source index and padding flag per item, and checks every result in order.
// Depends on sba_pkg, sba_in_if, sba_out_if and the top level of the block.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sba_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASE_ITEMS = 230;
    localparam int unsigned PRINT_CAP = 100;

    typedef struct packed {
        logic [9:0] out_batch;
        logic [9:0] channel;
        logic [9:0] out_row;
        logic [9:0] out_col;
    } coord_t;

    typedef struct packed {
        logic [33:0] source_index;
        logic        is_padding;
    } src_addr_t;

    class index_checker;
        int unsigned regs[8];
        src_addr_t   expected_addrs[$];
        int unsigned errors;

        function new();
            foreach (regs[i])
                regs[i] = (i == REG_PAD_TOP_ROWS || i == REG_PAD_LEFT_COLS) ? 0 : 1;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_IN_BATCH:                             regs[idx] = val & 32'h1F;
                REG_CHANNELS, REG_IN_HEIGHT, REG_IN_WIDTH: regs[idx] = val & 32'h7FF;
                REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT:        regs[idx] = val & 32'hF;
                default:                                  regs[idx] = val & 32'h3F;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        // Register value as the datapath uses it: sizes forced into their legal range
        function int unsigned eff(logic [2:0] idx);
            case (idx)
                REG_IN_BATCH:     return clamp(regs[idx], MAX_BATCH);
                REG_CHANNELS:     return clamp(regs[idx], MAX_CHANNELS);
                REG_IN_HEIGHT:    return clamp(regs[idx], MAX_HEIGHT);
                REG_IN_WIDTH:     return clamp(regs[idx], MAX_WIDTH);
                REG_BLOCK_WIDTH,
                REG_BLOCK_HEIGHT: return clamp(regs[idx], MAX_BLOCK);
                default:          return regs[idx];
            endcase
        endfunction

        function src_addr_t map_element(coord_t c);
            int unsigned nb, nc, nh, nw, bw, bh, pt, pl;
            int unsigned src_b, quo, sw, sh, prow, pcol;
            logic [63:0] flat;
            src_addr_t r;
            nb = eff(REG_IN_BATCH);
            nc = eff(REG_CHANNELS);
            nh = eff(REG_IN_HEIGHT);
            nw = eff(REG_IN_WIDTH);
            bw = eff(REG_BLOCK_WIDTH);
            bh = eff(REG_BLOCK_HEIGHT);
            pt = eff(REG_PAD_TOP_ROWS);
            pl = eff(REG_PAD_LEFT_COLS);
            src_b = c.out_batch % nb;
            quo = c.out_batch / nb;
            sw = quo % bw;
            sh = quo / bw;
            // sh may run past block_height and is added to the row as it is
            prow = c.out_row * bh + sh;
            pcol = c.out_col * bw + sw;
            r.is_padding = (prow < pt) || (prow >= pt + nh) || (pcol < pl) || (pcol >= pl + nw);
            r.source_index = '0;
            if (!r.is_padding)
            begin
                flat = ((64'(src_b) * nc + c.channel) * nh + (prow - pt)) * nw + (pcol - pl);
                r.source_index = flat[33:0];
            end
            return r;
        endfunction

        function void note_coord(coord_t c);
            expected_addrs.push_back(map_element(c));
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                         want);
            errors++;
        endtask

        task check_result(logic [33:0] idx, logic pad);
            src_addr_t want;
            if (expected_addrs.size() == 0)
            begin
                report("unexpected item", idx, 0);
                return;
            end
            want = expected_addrs.pop_front();
            if (idx !== want.source_index)
                report("source_index", idx, want.source_index);
            if (pad !== want.is_padding)
                report("is_padding", pad, want.is_padding);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    sba_in_if  din_ch();
    sba_out_if dout_ch();

    index_checker chk;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  cycle_count;

    // Idle modes: none, sender only, receiver only, both
    int unsigned  send_pct_by_mode[4] = '{0, 73, 0, 27};
    int unsigned  recv_pct_by_mode[4] = '{0, 0, 73, 27};

    space_to_batch_address_map dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_ch),
        .dout    (dout_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        dout_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din_ch.valid && din_ch.ready)
                chk.note_coord(coord_t'{din_ch.out_batch, din_ch.channel, din_ch.out_row,
                                        din_ch.out_col});
            if (dout_ch.valid && dout_ch.ready)
                chk.check_result(dout_ch.source_index, dout_ch.is_padding);
        end
    end

    task automatic apb_write(input logic [2:0] idx, input int unsigned val, input bit noisy);
        logic [31:0] word;
        // upper bits lie outside every register and must be dropped
        word = noisy ? (val | ($urandom & 32'hFFFF_0000)) : val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        chk.write_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_shape(input int unsigned b, c, h, w, bw, bh, pt, pl,
                               input bit noisy);
        apb_write(REG_IN_BATCH, b, noisy);
        apb_write(REG_CHANNELS, c, noisy);
        apb_write(REG_IN_HEIGHT, h, noisy);
        apb_write(REG_IN_WIDTH, w, noisy);
        apb_write(REG_BLOCK_WIDTH, bw, noisy);
        apb_write(REG_BLOCK_HEIGHT, bh, noisy);
        apb_write(REG_PAD_TOP_ROWS, pt, noisy);
        apb_write(REG_PAD_LEFT_COLS, pl, noisy);
    endtask

    // Mostly legal and small, sometimes full range, sometimes zero or past the maximum
    function automatic int unsigned pick_size(int unsigned legal_hi, int unsigned raw_hi,
                                              int unsigned usual_hi);
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return $urandom_range(0, 1) ? 0 : $urandom_range(legal_hi + 1, raw_hi);
        if (roll < 6)
            return $urandom_range(1, usual_hi);
        return $urandom_range(1, legal_hi);
    endfunction

    task automatic random_shape();
        write_shape(pick_size(MAX_BATCH, 31, MAX_BATCH),
                    pick_size(MAX_CHANNELS, 2047, MAX_CHANNELS),
                    pick_size(MAX_HEIGHT, 2047, 40),
                    pick_size(MAX_WIDTH, 2047, 40),
                    pick_size(MAX_BLOCK, 15, MAX_BLOCK),
                    pick_size(MAX_BLOCK, 15, MAX_BLOCK),
                    $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 8),
                    $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 8),
                    $urandom_range(0, 1));
    endtask

    function automatic int unsigned fit10(int unsigned x);
        return (x > 1023) ? 1023 : x;
    endfunction

    // Most coordinates land on the padded grid; one in eight is anything at all
    function automatic coord_t make_coord();
        int unsigned bw, bh;
        coord_t c;
        if ($urandom_range(0, 7) == 0)
        begin
            c.out_batch = 10'($urandom);
            c.channel   = 10'($urandom);
            c.out_row   = 10'($urandom);
            c.out_col   = 10'($urandom);
            return c;
        end
        bw = chk.eff(REG_BLOCK_WIDTH);
        bh = chk.eff(REG_BLOCK_HEIGHT);
        c.out_batch = 10'($urandom_range(0, fit10(chk.eff(REG_IN_BATCH) * bw * bh)));
        c.channel   = 10'($urandom_range(0, fit10(chk.eff(REG_CHANNELS) - 1)));
        c.out_row   = 10'($urandom_range(0, fit10((chk.eff(REG_PAD_TOP_ROWS)
                                                  + chk.eff(REG_IN_HEIGHT)) / bh + 1)));
        c.out_col   = 10'($urandom_range(0, fit10((chk.eff(REG_PAD_LEFT_COLS)
                                                  + chk.eff(REG_IN_WIDTH)) / bw + 1)));
        return c;
    endfunction

    task automatic send_item(input coord_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            din_ch.valid <= 1'b0;
            @(negedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.out_batch <= c.out_batch;
        din_ch.channel   <= c.channel;
        din_ch.out_row   <= c.out_row;
        din_ch.out_col   <= c.out_col;
        do
            @(posedge clk);
        while (!din_ch.ready);
    endtask

    // Drop valid and wait for every expected item to come back
    task automatic finish_burst();
        @(negedge clk);
        din_ch.valid <= 1'b0;
        while (chk.expected_addrs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        chk = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_ch.valid = 1'b0;
        din_ch.out_batch = '0;
        din_ch.channel = '0;
        din_ch.out_row = '0;
        din_ch.out_col = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset shape: channel past the count, row shift past the block grid
        send_item(coord_t'{10'd0, 10'd0, 10'd0, 10'd0});
        send_item(coord_t'{10'd0, 10'd1023, 10'd0, 10'd0});
        send_item(coord_t'{10'd1, 10'd0, 10'd0, 10'd0});
        send_item(coord_t'{10'd1023, 10'd1023, 10'd1023, 10'd1023});
        finish_burst();

        // Largest shape, no padding: the last element reaches the top index
        write_shape(16, 1024, 1024, 1024, 8, 8, 0, 0, 1'b0);
        send_item(coord_t'{10'd1023, 10'd1023, 10'd127, 10'd127});
        send_item(coord_t'{10'd15, 10'd0, 10'd0, 10'd0});
        send_item(coord_t'{10'd1008, 10'd5, 10'd127, 10'd0});
        send_item(coord_t'{10'd0, 10'd0, 10'd0, 10'd0});
        send_item(coord_t'{10'd1023, 10'd1023, 10'd1023, 10'd1023});
        finish_burst();

        // Full padding on top and left: edges of the padded frame
        write_shape(16, 1024, 1024, 1024, 8, 8, 63, 63, 1'b0);
        send_item(coord_t'{10'd0, 10'd0, 10'd7, 10'd7});
        send_item(coord_t'{10'd0, 10'd0, 10'd8, 10'd8});
        send_item(coord_t'{10'd1023, 10'd1023, 10'd134, 10'd134});
        send_item(coord_t'{10'd1023, 10'd0, 10'd135, 10'd135});
        finish_burst();

        // Zero and oversized register values saturate
        write_shape(0, 2047, 0, 2047, 15, 0, 0, 0, 1'b0);
        send_item(coord_t'{10'd1023, 10'd1023, 10'd0, 10'd127});
        send_item(coord_t'{10'd7, 10'd1023, 10'd0, 10'd127});
        send_item(coord_t'{10'd0, 10'd512, 10'd0, 10'd0});
        finish_burst();

        write_shape(31, 1, 1, 1, 0, 8, 0, 0, 1'b0);
        send_item(coord_t'{10'd3, 10'd0, 10'd0, 10'd0});
        send_item(coord_t'{10'd16, 10'd0, 10'd0, 10'd0});
        finish_burst();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       write_shape(16, 1024, 1024, 1024, 8, 8, 63, 63, 1'b1);
                1:       write_shape(1, 1, 1, 1, 1, 1, 0, 0, 1'b0);
                2:       write_shape(0, 0, 2047, 0, 0, 15, 63, 0, 1'b1);
                default: random_shape();
            endcase
            send_idle_pct = send_pct_by_mode[phase % 4];
            recv_stall_pct = recv_pct_by_mode[phase % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(make_coord());
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
